FILE: rtl/ffha_pkg.sv
// shared types, constants and codes for the first-fit heap allocator
package ffha_pkg;

   localparam int HEAP_BYTES    = 65536;
   localparam int HEADER_BYTES  = 8;
   localparam int GRANULE_BYTES = 8;

   localparam int OFFSET_W    = 16;
   localparam int MIN_BLOCK_W = 11;
   localparam logic [MIN_BLOCK_W-1:0] MIN_BLOCK_RESET = 11'd16;

   // heap is addressed in granules; headers are a whole number of granules
   localparam int UNIT_SHIFT = $clog2(GRANULE_BYTES);
   localparam int IDX_W      = OFFSET_W - UNIT_SHIFT;
   localparam int HDR_UNITS  = HEADER_BYTES / GRANULE_BYTES;
   localparam int NEED_W     = OFFSET_W + 2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic STATUS_DONE     = 1'b0;
   localparam logic STATUS_NO_SPACE = 1'b1;

   typedef struct packed {
      logic                opcode;
      logic [OFFSET_W-1:0] request_bytes;
      logic [OFFSET_W-1:0] release_offset;
   } ffha_req_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] granted_offset;
      logic                status;
   } ffha_rsp_type;

   // one block header, next link and capacity in granules
   typedef struct packed {
      logic             valid;
      logic             has_next;
      logic             is_free;
      logic [IDX_W-1:0] next_idx;
      logic [IDX_W-1:0] cap_units;
   } ffha_hdr_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_PREP,
      ST_AWALK,
      ST_ASPLIT,
      ST_ATAIL,
      ST_FCHECK,
      ST_FMERGE,
      ST_FWRITE,
      ST_RESP
   } ffha_state_type;

endpackage

FILE: rtl/ffha_ram.sv
// generic simple dual-port ram with registered read
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/first_fit_heap_allocator_unit.sv
// first-fit heap allocator: header walk, split on allocate, forward merge on free
// Allocate reads one header from ram per header visited, or reports no space when no block fits.
// Free merges forward into free successors; a stale header or a rejected offset is answered
// without merging. The next request is taken in the cycle after the result loads.
// Reset (synchronous): the whole-heap free header is written at offset 0, then idle;
// other header entries stay unwritten, min_block_ff returns to 16 bytes.
module first_fit_heap_allocator_unit #(
   parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  ffha_pkg::ffha_req_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ffha_pkg::ffha_rsp_type               rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [ffha_pkg::MIN_BLOCK_W-1:0]     csr_wr_data
);

   localparam int DEPTH  = HEAP_BYTES / ffha_pkg::GRANULE_BYTES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int HDR_W  = $bits(ffha_pkg::ffha_hdr_type);
   localparam int IDX_W  = ffha_pkg::IDX_W;
   localparam int OFS_W  = ffha_pkg::OFFSET_W;
   localparam int SHIFT  = ffha_pkg::UNIT_SHIFT;
   localparam int NEED_W = ffha_pkg::NEED_W;

   ffha_pkg::ffha_state_type state_ff, state_in;

   logic [ffha_pkg::MIN_BLOCK_W-1:0] min_block_ff;
   ffha_pkg::ffha_req_type           req_ff, req_in;
   logic [IDX_W:0]                   q_units_ff, q_units_in;
   logic [NEED_W-1:0]                need_ff, need_in;
   logic [IDX_W-1:0]                 cur_ff, cur_in;
   ffha_pkg::ffha_hdr_type           hdr_ff, hdr_in;
   logic [IDX_W-1:0]                 split_ff, split_in;
   logic [IDX_W-1:0]                 rem_ff, rem_in;
   ffha_pkg::ffha_rsp_type           res_ff, res_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   ffha_pkg::ffha_rsp_type           rsp_data_ff, rsp_data_in;

   // header ram
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   ffha_pkg::ffha_hdr_type wr_hdr;
   logic [ADDR_W-1:0]      rd_addr;
   logic [HDR_W-1:0]       rd_data;
   ffha_pkg::ffha_hdr_type rd_hdr;

   // datapath
   logic [OFS_W-1:0]  q_floor;
   logic [OFS_W:0]    q_sum;
   logic [IDX_W:0]    q_units_c;
   logic [OFS_W:0]    q_bytes_c;
   logic [NEED_W-1:0] need_c;
   logic [OFS_W-1:0]  at_bytes;
   logic [IDX_W-1:0]  at_idx;
   logic              free_ok;
   logic [NEED_W-1:0] cap_bytes;
   logic              fits;
   logic [IDX_W-1:0]  split_c;
   logic [IDX_W-1:0]  rem_c;
   logic [IDX_W:0]    grant_idx;
   logic [OFS_W:0]    grant_bytes;
   logic [IDX_W:0]    adj_c;
   logic              merge_ok;
   logic [IDX_W-1:0]  merge_cap;

   ffha_ram #(
      .WIDTH (HDR_W),
      .DEPTH (DEPTH)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_hdr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_hdr = ffha_pkg::ffha_hdr_type'(rd_data);

   // request sizing: raise to minimum, round up to the granule
   assign q_floor   = (req_ff.request_bytes < OFS_W'(min_block_ff)) ?
                      OFS_W'(min_block_ff) : req_ff.request_bytes;
   assign q_sum     = {1'b0, q_floor} + (OFS_W+1)'(ffha_pkg::GRANULE_BYTES - 1);
   assign q_units_c = q_sum[OFS_W:SHIFT];
   assign q_bytes_c = {q_units_c, {SHIFT{1'b0}}};
   assign need_c    = NEED_W'(q_bytes_c) + NEED_W'(ffha_pkg::HEADER_BYTES)
                    + NEED_W'(min_block_ff);

   // free: header sits one header below the payload offset
   assign at_bytes = req_ff.release_offset - OFS_W'(ffha_pkg::HEADER_BYTES);
   assign at_idx   = at_bytes[OFS_W-1:SHIFT];
   assign free_ok  = (req_ff.release_offset >= OFS_W'(ffha_pkg::HEADER_BYTES))
                  && (at_bytes[SHIFT-1:0] == '0)
                  && ({1'b0, at_idx} < (IDX_W+1)'(DEPTH));

   assign cap_bytes = NEED_W'({rd_hdr.cap_units, {SHIFT{1'b0}}});
   assign fits      = rd_hdr.is_free && (cap_bytes >= need_ff);

   assign split_c = cur_ff + IDX_W'(ffha_pkg::HDR_UNITS) + q_units_ff[IDX_W-1:0];
   assign rem_c   = hdr_ff.cap_units - q_units_ff[IDX_W-1:0] - IDX_W'(ffha_pkg::HDR_UNITS);

   assign grant_idx   = {1'b0, cur_ff} + (IDX_W+1)'(ffha_pkg::HDR_UNITS);
   assign grant_bytes = {grant_idx, {SHIFT{1'b0}}};

   // successor must start right behind the accumulated block and be free
   assign adj_c     = {1'b0, cur_ff} + (IDX_W+1)'(ffha_pkg::HDR_UNITS)
                    + {1'b0, hdr_ff.cap_units};
   assign merge_ok  = rd_hdr.valid && rd_hdr.is_free && ({1'b0, hdr_ff.next_idx} == adj_c);
   assign merge_cap = hdr_ff.cap_units + IDX_W'(ffha_pkg::HDR_UNITS) + rd_hdr.cap_units;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      q_units_in   = q_units_ff;
      need_in      = need_ff;
      cur_in       = cur_ff;
      hdr_in       = hdr_ff;
      split_in     = split_ff;
      rem_in       = rem_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = cur_ff[ADDR_W-1:0];
      wr_hdr       = hdr_ff;
      rd_addr      = cur_ff[ADDR_W-1:0];

      unique case (state_ff)
         ffha_pkg::ST_INIT: begin
            wr_en            = 1'b1;
            wr_addr          = '0;
            wr_hdr.valid     = 1'b1;
            wr_hdr.has_next  = 1'b0;
            wr_hdr.is_free   = 1'b1;
            wr_hdr.next_idx  = '0;
            wr_hdr.cap_units = IDX_W'(DEPTH - ffha_pkg::HDR_UNITS);
            state_in         = ffha_pkg::ST_IDLE;
         end
         ffha_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_data;
               state_in = ffha_pkg::ST_PREP;
            end
         end
         ffha_pkg::ST_PREP: begin
            q_units_in = q_units_c;
            need_in    = need_c;
            if (req_ff.opcode == ffha_pkg::OP_ALLOC) begin
               cur_in   = '0;
               rd_addr  = '0;
               state_in = ffha_pkg::ST_AWALK;
            end else if (free_ok) begin
               cur_in   = at_idx;
               rd_addr  = at_idx[ADDR_W-1:0];
               state_in = ffha_pkg::ST_FCHECK;
            end else begin
               res_in.granted_offset = '0;
               res_in.status         = ffha_pkg::STATUS_DONE;
               state_in              = ffha_pkg::ST_RESP;
            end
         end
         ffha_pkg::ST_AWALK: begin
            if (rd_hdr.valid && fits) begin
               hdr_in   = rd_hdr;
               state_in = ffha_pkg::ST_ASPLIT;
            end else if (!rd_hdr.valid || !rd_hdr.has_next || rd_hdr.next_idx <= cur_ff) begin
               res_in.granted_offset = '0;
               res_in.status         = ffha_pkg::STATUS_NO_SPACE;
               state_in              = ffha_pkg::ST_RESP;
            end else begin
               // follow the link, data shows up next cycle
               cur_in  = rd_hdr.next_idx;
               rd_addr = rd_hdr.next_idx[ADDR_W-1:0];
            end
         end
         ffha_pkg::ST_ASPLIT: begin
            wr_en            = 1'b1;
            wr_hdr.valid     = 1'b1;
            wr_hdr.has_next  = 1'b1;
            wr_hdr.is_free   = 1'b0;
            wr_hdr.next_idx  = split_c;
            wr_hdr.cap_units = q_units_ff[IDX_W-1:0];
            split_in         = split_c;
            rem_in           = rem_c;
            state_in         = ffha_pkg::ST_ATAIL;
         end
         ffha_pkg::ST_ATAIL: begin
            wr_en                 = 1'b1;
            wr_addr               = split_ff[ADDR_W-1:0];
            wr_hdr.valid          = 1'b1;
            wr_hdr.has_next       = hdr_ff.has_next;
            wr_hdr.is_free        = 1'b1;
            wr_hdr.next_idx       = hdr_ff.next_idx;
            wr_hdr.cap_units      = rem_ff;
            res_in.granted_offset = grant_bytes[OFS_W-1:0];
            res_in.status         = ffha_pkg::STATUS_DONE;
            state_in              = ffha_pkg::ST_RESP;
         end
         ffha_pkg::ST_FCHECK: begin
            res_in.granted_offset = '0;
            res_in.status         = ffha_pkg::STATUS_DONE;
            if (!rd_hdr.valid) begin
               state_in = ffha_pkg::ST_RESP;
            end else begin
               hdr_in         = rd_hdr;
               hdr_in.is_free = 1'b1;
               if (rd_hdr.has_next) begin
                  rd_addr  = rd_hdr.next_idx[ADDR_W-1:0];
                  state_in = ffha_pkg::ST_FMERGE;
               end else begin
                  state_in = ffha_pkg::ST_FWRITE;
               end
            end
         end
         ffha_pkg::ST_FMERGE: begin
            if (merge_ok) begin
               // retire the absorbed header and fetch the one after it
               wr_en            = 1'b1;
               wr_addr          = hdr_ff.next_idx[ADDR_W-1:0];
               wr_hdr           = rd_hdr;
               wr_hdr.valid     = 1'b0;
               hdr_in.cap_units = merge_cap;
               hdr_in.has_next  = rd_hdr.has_next;
               hdr_in.next_idx  = rd_hdr.next_idx;
               rd_addr          = rd_hdr.next_idx[ADDR_W-1:0];
               if (!rd_hdr.has_next) begin
                  state_in = ffha_pkg::ST_FWRITE;
               end
            end else begin
               state_in = ffha_pkg::ST_FWRITE;
            end
         end
         ffha_pkg::ST_FWRITE: begin
            wr_en    = 1'b1;
            wr_hdr   = hdr_ff;
            state_in = ffha_pkg::ST_RESP;
         end
         ffha_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ffha_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffha_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffha_pkg::ST_INIT;
         rsp_valid_ff <= 1'b0;
         min_block_ff <= ffha_pkg::MIN_BLOCK_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            min_block_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      q_units_ff  <= q_units_in;
      need_ff     <= need_in;
      cur_ff      <= cur_in;
      hdr_ff      <= hdr_in;
      split_ff    <= split_in;
      rem_ff      <= rem_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // first-fit walk only moves forward through the chain
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ffha_pkg::ST_AWALK && $past(state_ff) == ffha_pkg::ST_AWALK)
      |-> cur_ff > $past(cur_ff))
      else $error("allocate walk did not advance");

   // split point lies behind the block being split
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ffha_pkg::ST_ASPLIT) |-> split_c > cur_ff)
      else $error("split header not past the used block");

   // a new result only comes from the response state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ffha_pkg::ST_RESP)
      else $error("result appeared outside response state");

   // granted offsets are granule aligned, failures report zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.granted_offset[SHIFT-1:0] == '0)
         && (rsp_data_ff.status == ffha_pkg::STATUS_DONE
             || rsp_data_ff.granted_offset == '0))
      else $error("bad granted offset");

endmodule
